// ----- rtl/sos_pkg.sv -----
// ----------------------------------------------------------------------------
// sos_pkg
// Shared constants and types for the shell operator spacer.
// ----------------------------------------------------------------------------
package sos_pkg;

    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_MORE   = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    localparam logic [1:0] QM_NONE   = 2'd0;
    localparam logic [1:0] QM_SINGLE = 2'd1;
    localparam logic [1:0] QM_DOUBLE = 2'd2;

    localparam int CMD_BYTES   = 6;
    localparam int IDX_W       = $clog2(CMD_BYTES);
    localparam int CNT_W       = $clog2(CMD_BYTES + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [CMD_BYTES-1:0][7:0] data;
        logic [CNT_W-1:0]          count;
        logic                      last;
    } t_cmd;

endpackage

// ----- rtl/shell_operator_spacer.sv -----
// ----------------------------------------------------------------------------
// shell_operator_spacer
// Copies a shell command line byte by byte, padding unquoted, unescaped
// pipe and redirection operators with one space on each side.
// Throughput: one input beat per cycle while the two-entry queue has room;
// the output side sends one byte per cycle while i_ready is high, and an
// input beat yields 0 to 6 output bytes.
// Reset: synchronous, active low; clears quoting, held operator and queue,
// and sets spacing to enabled.
// ----------------------------------------------------------------------------
module shell_operator_spacer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte_in,
    input  logic       i_end_of_line,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte_out,
    output logic       o_last_out
);

    sos_pkg::t_cmd push_cmd;
    sos_pkg::t_cmd head_cmd;
    logic          push;
    logic          full;
    logic          pop;
    logic          empty;

    sos_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_byte_in     (i_byte_in),
        .i_end_of_line (i_end_of_line),
        .i_full        (full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    sos_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    sos_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_cmd      (head_cmd),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_byte_out (o_byte_out),
        .o_last_out (o_last_out)
    );

endmodule

// ----- rtl/sos_front.sv -----
// ----------------------------------------------------------------------------
// sos_front
// Accepts input beats, tracks quoting and held operators, and builds the
// list of output bytes that each beat produces.
// ----------------------------------------------------------------------------
module sos_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_data,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte_in,
    input  logic          i_end_of_line,
    input  logic          i_full,
    output logic          o_push,
    output sos_pkg::t_cmd o_cmd
);

    logic       r_en;
    logic [1:0] r_quote, n_quote;
    logic [7:0] r_prev, n_prev;
    logic       r_pv, n_pv;
    logic [7:0] r_pc, n_pc;
    logic       r_pe, n_pe;

    sos_pkg::t_cmd cmd;
    logic [sos_pkg::CNT_W-1:0] cnt;
    logic esc;
    logic in_q;
    logic is_op;
    logic match;
    logic accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_quote = r_quote;
        n_prev  = r_prev;
        n_pv    = r_pv;
        n_pc    = r_pc;
        n_pe    = r_pe;
        cmd     = '0;
        cnt     = '0;
        esc     = (r_prev == sos_pkg::CH_BSLASH);
        is_op   = (i_byte_in == sos_pkg::CH_LESS) || (i_byte_in == sos_pkg::CH_MORE);
        match   = r_en && r_pv && (i_byte_in == r_pc);

        in_q = 1'b1;
        if (r_quote != sos_pkg::QM_NONE) begin
            if ((r_quote == sos_pkg::QM_SINGLE && i_byte_in == sos_pkg::CH_SQUOTE) ||
                (r_quote == sos_pkg::QM_DOUBLE && i_byte_in == sos_pkg::CH_DQUOTE)) begin
                n_quote = sos_pkg::QM_NONE;
            end
        end else if (i_byte_in == sos_pkg::CH_SQUOTE) begin
            n_quote = sos_pkg::QM_SINGLE;
        end else if (i_byte_in == sos_pkg::CH_DQUOTE) begin
            n_quote = sos_pkg::QM_DOUBLE;
        end else begin
            in_q = 1'b0;
        end

        // Flush a held operator that does not pair with this byte.
        if (r_pv && !match) begin
            if (r_pe) begin
                cmd.data[cnt[sos_pkg::IDX_W-1:0]] = r_pc;
                cnt = cnt + 1'b1;
            end else begin
                cmd.data[cnt[sos_pkg::IDX_W-1:0]] = sos_pkg::CH_SPACE;
                cnt = cnt + 1'b1;
                cmd.data[cnt[sos_pkg::IDX_W-1:0]] = r_pc;
                cnt = cnt + 1'b1;
                cmd.data[cnt[sos_pkg::IDX_W-1:0]] = sos_pkg::CH_SPACE;
                cnt = cnt + 1'b1;
            end
        end
        n_pv = 1'b0;
        n_pc = '0;
        n_pe = 1'b0;

        if (!r_en) begin
            cmd.data[cnt[sos_pkg::IDX_W-1:0]] = i_byte_in;
            cnt = cnt + 1'b1;
        end else if (match) begin
            if (r_pe) begin
                cmd.data[cnt[sos_pkg::IDX_W-1:0]] = r_pc;
                cnt = cnt + 1'b1;
                cmd.data[cnt[sos_pkg::IDX_W-1:0]] = i_byte_in;
                cnt = cnt + 1'b1;
            end else begin
                cmd.data[cnt[sos_pkg::IDX_W-1:0]] = sos_pkg::CH_SPACE;
                cnt = cnt + 1'b1;
                cmd.data[cnt[sos_pkg::IDX_W-1:0]] = r_pc;
                cnt = cnt + 1'b1;
                cmd.data[cnt[sos_pkg::IDX_W-1:0]] = i_byte_in;
                cnt = cnt + 1'b1;
                cmd.data[cnt[sos_pkg::IDX_W-1:0]] = sos_pkg::CH_SPACE;
                cnt = cnt + 1'b1;
            end
        end else if (in_q) begin
            cmd.data[cnt[sos_pkg::IDX_W-1:0]] = i_byte_in;
            cnt = cnt + 1'b1;
        end else if (is_op) begin
            n_pv = 1'b1;
            n_pc = i_byte_in;
            n_pe = esc;
        end else if (i_byte_in == sos_pkg::CH_PIPE && !esc) begin
            cmd.data[cnt[sos_pkg::IDX_W-1:0]] = sos_pkg::CH_SPACE;
            cnt = cnt + 1'b1;
            cmd.data[cnt[sos_pkg::IDX_W-1:0]] = i_byte_in;
            cnt = cnt + 1'b1;
            cmd.data[cnt[sos_pkg::IDX_W-1:0]] = sos_pkg::CH_SPACE;
            cnt = cnt + 1'b1;
        end else begin
            cmd.data[cnt[sos_pkg::IDX_W-1:0]] = i_byte_in;
            cnt = cnt + 1'b1;
        end
        n_prev = i_byte_in;

        if (i_end_of_line) begin
            if (n_pv) begin
                if (n_pe) begin
                    cmd.data[cnt[sos_pkg::IDX_W-1:0]] = n_pc;
                    cnt = cnt + 1'b1;
                end else begin
                    cmd.data[cnt[sos_pkg::IDX_W-1:0]] = sos_pkg::CH_SPACE;
                    cnt = cnt + 1'b1;
                    cmd.data[cnt[sos_pkg::IDX_W-1:0]] = n_pc;
                    cnt = cnt + 1'b1;
                    cmd.data[cnt[sos_pkg::IDX_W-1:0]] = sos_pkg::CH_SPACE;
                    cnt = cnt + 1'b1;
                end
            end
            n_pv     = 1'b0;
            n_pc     = '0;
            n_pe     = 1'b0;
            n_quote  = sos_pkg::QM_NONE;
            n_prev   = '0;
            cmd.last = 1'b1;
        end
        cmd.count = cnt;
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en    <= 1'b1;
            r_quote <= sos_pkg::QM_NONE;
            r_prev  <= '0;
            r_pv    <= 1'b0;
            r_pc    <= '0;
            r_pe    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_en <= i_cfg_data;
            end
            if (accept) begin
                r_quote <= n_quote;
                r_prev  <= n_prev;
                r_pv    <= n_pv;
                r_pc    <= n_pc;
                r_pe    <= n_pe;
            end
        end
    end

endmodule

// ----- rtl/sos_queue.sv -----
// ----------------------------------------------------------------------------
// sos_queue
// Short queue of byte lists between the front and the back.
// ----------------------------------------------------------------------------
module sos_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sos_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output sos_pkg::t_cmd o_cmd
);

    sos_pkg::t_cmd r_mem [sos_pkg::QUEUE_DEPTH];
    logic [sos_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [sos_pkg::QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == sos_pkg::QCNT_W'(sos_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == sos_pkg::QPTR_W'(sos_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == sos_pkg::QPTR_W'(sos_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/sos_back.sv -----
// ----------------------------------------------------------------------------
// sos_back
// Takes byte lists from the queue and sends them one output beat per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module sos_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  sos_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte_out,
    output logic          o_last_out
);

    logic                      r_busy;
    sos_pkg::t_cmd             r_cmd;
    logic [sos_pkg::IDX_W-1:0] r_idx;
    logic                      final_byte;
    logic                      done;

    assign final_byte = (sos_pkg::CNT_W'(r_idx) == r_cmd.count - 1'b1);
    assign done       = !r_busy || (i_ready && final_byte);
    assign o_pop      = done && !i_empty;
    assign o_valid    = r_busy;
    assign o_byte_out = r_cmd.data[r_idx];
    assign o_last_out = r_cmd.last && final_byte;

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (done) begin
            r_busy <= !i_empty;
            r_idx  <= '0;
        end else if (i_ready) begin
            r_idx <= r_idx + 1'b1;
        end
    end

endmodule
